>>> hw/rtl/wcmp_pkg.sv
`timescale 1ns / 1ps

package wcmp_pkg;

   // channel and colour widths
   localparam int CHAN_W  = 8;
   localparam int KEY_W   = 3 * CHAN_W;
   localparam int COUNT_W = 5;

   // counts stop growing here
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 5'd1;

   // one pixel of the sample window
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_pixel;
   } req_word_type;

   // one window result
   typedef struct packed {
      logic              found;
      logic [CHAN_W-1:0] pick_red;
      logic [CHAN_W-1:0] pick_green;
      logic [CHAN_W-1:0] pick_blue;
   } rsp_word_type;

   // control from the pipeline into the colour table
   typedef struct packed {
      logic fire;
      logic last;
      logic black;
   } tbl_ctl_type;

   // winning colour after the current pixel is counted
   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] colour;
   } tbl_pick_type;

endpackage

>>> hw/rtl/wcmp_table.sv
`timescale 1ns / 1ps

module wcmp_table #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  wcmp_pkg::tbl_ctl_type       ctl,
   input  logic [wcmp_pkg::KEY_W-1:0]  key,
   output wcmp_pkg::tbl_pick_type      pick
);

   localparam int USED_W = $clog2(DEPTH + 1);

   logic [wcmp_pkg::KEY_W-1:0]   key_ff   [DEPTH];
   logic [wcmp_pkg::COUNT_W-1:0] count_ff [DEPTH];
   logic [USED_W-1:0]            used_ff, used_in;
   logic [wcmp_pkg::COUNT_W-1:0] best_count_ff, best_count_in;
   logic [wcmp_pkg::KEY_W-1:0]   best_colour_ff, best_colour_in;

   logic [DEPTH-1:0]             hit;
   logic                         any_hit;
   logic                         full;
   logic                         counted;
   logic [wcmp_pkg::COUNT_W-1:0] hit_count;
   logic [wcmp_pkg::COUNT_W-1:0] new_count;
   logic                         take_best;
   logic [wcmp_pkg::COUNT_W-1:0] best_count_nx;
   logic [wcmp_pkg::KEY_W-1:0]   best_colour_nx;

   // parallel compare against every filled entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = (USED_W'(i) < used_ff) && (key_ff[i] == key);
      end
   end

   // keys are unique, so the matching count is an or of masked counts
   always_comb begin
      hit_count = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_count = hit_count | ({wcmp_pkg::COUNT_W{hit[i]}} & count_ff[i]);
      end
   end

   assign any_hit = |hit;
   assign full    = (used_ff == USED_W'(DEPTH));
   assign counted = !ctl.black && (any_hit || !full);

   // saturating count, or one for a colour taking a fresh entry
   always_comb begin
      if (!any_hit) begin
         new_count = wcmp_pkg::COUNT_ONE;
      end else if (hit_count == wcmp_pkg::COUNT_MAX) begin
         new_count = wcmp_pkg::COUNT_MAX;
      end else begin
         new_count = hit_count + wcmp_pkg::COUNT_ONE;
      end
   end

   // best only moves on a strictly larger count
   assign take_best      = counted && (new_count > best_count_ff);
   assign best_count_nx  = take_best ? new_count : best_count_ff;
   assign best_colour_nx = take_best ? key : best_colour_ff;

   assign pick.found  = (best_count_nx != '0);
   assign pick.colour = best_colour_nx;

   // fill count and running best, cleared at the end of each window
   always_comb begin
      used_in        = used_ff;
      best_count_in  = best_count_ff;
      best_colour_in = best_colour_ff;
      if (ctl.fire) begin
         if (ctl.last) begin
            used_in        = '0;
            best_count_in  = '0;
            best_colour_in = '0;
         end else begin
            if (counted && !any_hit) begin
               used_in = used_ff + USED_W'(1);
            end
            best_count_in  = best_count_nx;
            best_colour_in = best_colour_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= '0;
         best_count_ff  <= '0;
         best_colour_ff <= '0;
      end else begin
         used_ff        <= used_in;
         best_count_ff  <= best_count_in;
         best_colour_ff <= best_colour_in;
      end
   end

   // key/count cells, one per entry
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                         fill;
      logic [wcmp_pkg::KEY_W-1:0]   key_in;
      logic [wcmp_pkg::COUNT_W-1:0] count_in;

      assign fill = ctl.fire && counted && !any_hit && (used_ff == USED_W'(g));

      always_comb begin
         key_in   = key_ff[g];
         count_in = count_ff[g];
         if (fill) begin
            key_in   = key;
            count_in = wcmp_pkg::COUNT_ONE;
         end else if (ctl.fire && !ctl.black && hit[g]) begin
            count_in = new_count;
         end
      end

      always_ff @(posedge clock) begin
         key_ff[g]   <= key_in;
         count_ff[g] <= count_in;
      end
   end

   // checks
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit)) else $error("several table entries match one colour");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(DEPTH)) else $error("fill count beyond table depth");

   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      (best_count_ff == '0) |-> (best_colour_ff == '0))
      else $error("best colour set without a count");

   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && ctl.last) |=> (used_ff == '0 && best_count_ff == '0))
      else $error("table not cleared after last pixel");

endmodule

>>> hw/rtl/window_color_mode_picker.sv
`timescale 1ns / 1ps

// Most frequent non-black colour of a square sample window. Pixels enter one
// word per cycle in raster order; black pixels are skipped, the rest are
// counted in a key/count table of WINDOW_SIDE squared entries, each entry
// compared in parallel. A word with last_pixel set produces one result word
// (found clear and colour zero if every pixel was black) via the input and
// result registers, and the table starts empty for the next window. Sustained
// rate is one pixel per cycle while the input is not held off, set by the
// combinational compare-and-count over the whole table. The input holds off
// only while a last pixel waits behind a result word that has not yet been
// taken. Counts saturate at 31, and colours beyond a full table are not counted.
module window_color_mode_picker #(
   parameter int WINDOW_SIDE = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wcmp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wcmp_pkg::rsp_word_type rsp_word
);

   localparam int DEPTH = WINDOW_SIDE * WINDOW_SIDE;

   wcmp_pkg::req_word_type req_ff, req_in;
   logic                   req_valid_ff, req_valid_in;
   wcmp_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   fire;
   wcmp_pkg::tbl_ctl_type  ctl;
   wcmp_pkg::tbl_pick_type pick;

   // the held pixel goes through unless it ends a window and the result slot is busy
   assign fire      = req_valid_ff && (!req_ff.last_pixel || !rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   // input register
   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff && !fire;
      if (accept) begin
         req_in       = req_word;
         req_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_ff <= req_in;
   end

   assign ctl.fire  = fire;
   assign ctl.last  = req_ff.last_pixel;
   assign ctl.black = (req_ff.red == '0) && (req_ff.green == '0) && (req_ff.blue == '0);

   wcmp_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .key   ({req_ff.red, req_ff.green, req_ff.blue}),
      .pick  (pick)
   );

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire && req_ff.last_pixel) begin
         rsp_in.found      = pick.found;
         rsp_in.pick_red   = pick.colour[23:16];
         rsp_in.pick_green = pick.colour[15:8];
         rsp_in.pick_blue  = pick.colour[7:0];
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   a_last_gives_word: assert property (@(posedge clock) disable iff (reset)
      (fire && req_ff.last_pixel) |=> rsp_valid_ff)
      else $error("last pixel gave no result word");

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && req_ff.last_pixel && rsp_valid_ff))
      else $error("input held off without a pending result");

   a_no_word_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(fire && req_ff.last_pixel))
      else $error("result word overwritten while waiting");

endmodule
